// ===== src/sht_pkg.sv =====
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the symbol hash table: opcodes, result
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package sht_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_CHARS_DEF   = 6;
  localparam int CHAR_W          = 7;
  localparam int VALUE_W         = 16;
  localparam int OP_W            = 2;
  localparam int STAT_W          = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DEFINE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } sht_state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_start;
    logic probe_advance;
    logic clear_wr;
    logic emit;
  } sht_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic cnt_last;
    logic probe_stop;
    logic out_free;
  } sht_sts_t;

endpackage

// ===== src/sht_ctrl.sv =====
// ----------------------------------------------------------------------------
// sht_ctrl
// Sequencer for the symbol hash table: clearing pass after reset, item
// intake, hashing, and the linear probe walk.
// ----------------------------------------------------------------------------
module sht_ctrl
  import sht_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sht_sts_t sts,
  output sht_cmd_t cmd
);

  sht_state_t state;
  sht_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.probe_start = 1'b1;
        state_next      = S_CHECK;
      end
      S_CHECK: begin
        // stop on match or empty slot, or when every slot has been tried
        if (sts.probe_stop || sts.cnt_last) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.probe_advance = 1'b1;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/sht_dpath.sv =====
// ----------------------------------------------------------------------------
// sht_dpath
// Datapath of the symbol hash table: item registers, incremental hash with
// modulo reduction, slot and probe counters, entry memory and result register.
// ----------------------------------------------------------------------------
module sht_dpath
  import sht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  localparam int IDX_W      = $clog2(TABLE_SLOTS),
  localparam int KEY_W      = 8 * KEY_CHARS
)(
  input  logic               clk,
  input  logic               rst,
  input  sht_cmd_t           cmd,
  output sht_sts_t           sts,
  input  logic [OP_W-1:0]    opcode,
  input  logic [KEY_W-1:0]   key_chars,
  input  logic [VALUE_W-1:0] new_value,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [STAT_W-1:0]  status,
  output logic [IDX_W-1:0]   slot_index,
  output logic               was_defined,
  output logic [VALUE_W-1:0] stored_value
);

  localparam int PK_W = CHAR_W * KEY_CHARS;
  localparam int MW   = PK_W + VALUE_W + 1;
  localparam int CW   = $clog2(KEY_CHARS + 1);
  localparam int RW   = IDX_W + 4;
  localparam logic [RW-1:0]    N1       = RW'(TABLE_SLOTS);
  localparam logic [RW-1:0]    N2       = RW'(2 * TABLE_SLOTS);
  localparam logic [RW-1:0]    N4       = RW'(4 * TABLE_SLOTS);
  localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0]    CHAR_MAX = CW'(KEY_CHARS - 1);

  logic [OP_W-1:0]    op_reg;
  logic [KEY_W-1:0]   key_reg;
  logic [VALUE_W-1:0] nv_reg;
  logic [CW-1:0]      char_cnt;
  logic [IDX_W-1:0]   hash_r;
  logic [IDX_W-1:0]   hash_next;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   slot_inc;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [MW-1:0]      wr_data;
  logic               wr_en;
  logic [MW-1:0]      rd_data;
  logic [PK_W-1:0]    packed_key;
  logic [CHAR_W-1:0]  ch;
  logic [CW-1:0]      char_sel;
  logic               zero_key;
  logic               slot_empty;
  logic               slot_match;
  logic               is_full;
  logic               do_write;
  logic               do_define;
  logic [RW-1:0]      acc;
  logic [RW-1:0]      cm;
  logic [RW-1:0]      sum;

  logic [MW-1:0] mem [TABLE_SLOTS];

  // packed key: low 7 bits of each byte, first character on top
  for (genvar g = 0; g < KEY_CHARS; g++) begin : g_pack
    assign packed_key[CHAR_W*g +: CHAR_W] = key_reg[8*g +: CHAR_W];
  end

  assign zero_key = (key_reg[KEY_W-8 +: CHAR_W] == '0);
  assign char_sel = CHAR_MAX - char_cnt;
  assign ch       = key_reg[{char_sel, 3'b000} +: CHAR_W];

  // h = (4h + c) mod TABLE_SLOTS, kept reduced after every character
  always_comb begin
    acc = {3'b000, hash_r, 1'b0};
    if (acc >= N1) acc = acc - N1;
    acc = {acc[RW-2:0], 1'b0};
    if (acc >= N1) acc = acc - N1;
    cm = {{(RW-CHAR_W){1'b0}}, ch};
    if (cm >= N4) cm = cm - N4;
    if (cm >= N2) cm = cm - N2;
    if (cm >= N1) cm = cm - N1;
    sum = acc + cm;
    if (sum >= N1) sum = sum - N1;
    hash_next = sum[IDX_W-1:0];
  end

  assign slot_inc = (slot == SLOT_MAX) ? '0 : slot + 1'b1;

  always_comb begin
    priority if (cmd.probe_start) begin
      rd_addr = hash_r;
    end else if (cmd.probe_advance) begin
      rd_addr = slot_inc;
    end else begin
      rd_addr = slot;
    end
  end

  assign slot_empty = (rd_data[MW-1 -: CHAR_W] == '0);
  assign slot_match = (rd_data[MW-1 -: PK_W] == packed_key);
  assign is_full    = !(slot_empty || slot_match);
  assign do_define  = (op_reg == OP_DEFINE) && !zero_key;
  assign do_write   = !is_full && !zero_key && (op_reg == OP_INSERT || op_reg == OP_DEFINE);

  assign wr_en   = cmd.clear_wr || (cmd.emit && do_write);
  assign wr_addr = cmd.clear_wr ? cnt : slot;
  assign wr_data = cmd.clear_wr ? '0 :
                   {packed_key,
                    do_define ? nv_reg : rd_data[1 +: VALUE_W],
                    do_define | rd_data[0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // item registers, hash accumulator and probe slot register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg   <= opcode;
      key_reg  <= key_chars;
      nv_reg   <= new_value;
      char_cnt <= '0;
      hash_r   <= '0;
    end else if (cmd.hash_step) begin
      char_cnt <= char_cnt + 1'b1;
      hash_r   <= hash_next;
    end
    if (cmd.probe_start) begin
      slot <= hash_r;
    end else if (cmd.probe_advance) begin
      slot <= slot_inc;
    end
  end

  // shared counter: clearing pass address, then probe count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear_wr) begin
      cnt <= (cnt == SLOT_MAX) ? '0 : cnt + 1'b1;
    end else if (cmd.probe_start) begin
      cnt <= '0;
    end else if (cmd.probe_advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (is_full) begin
        status       <= STAT_FULL;
        slot_index   <= '0;
        was_defined  <= 1'b0;
        stored_value <= '0;
      end else begin
        status       <= slot_empty ? STAT_EMPTY : STAT_FOUND;
        slot_index   <= slot;
        was_defined  <= rd_data[0];
        stored_value <= do_define ? nv_reg : rd_data[1 +: VALUE_W];
      end
    end
  end

  assign sts.hash_last  = (char_cnt == CHAR_MAX);
  assign sts.cnt_last   = (cnt == SLOT_MAX);
  assign sts.probe_stop = !is_full;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// ===== src/symbol_hash_table.sv =====
// Symbol hash table: an open-addressed table of TABLE_SLOTS entries keyed by
// KEY_CHARS space-padded 7-bit characters, probed linearly from the home slot
// (4h+c hash over the characters, modulo TABLE_SLOTS). After reset the block
// runs a clearing pass over all TABLE_SLOTS entries with in_stall high. Each
// item then goes through intake, hashing (one character per cycle), issue of
// the first read, and the linear probe walk on the entry memory (one read per
// cycle, one slot per read). One item is worked on at a
// time; the result register lets the next item enter while a result is still
// waiting on out_stall.
// ----------------------------------------------------------------------------
// symbol_hash_table
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
module symbol_hash_table
  import sht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = KEY_CHARS_DEF,
  localparam int IDX_W      = $clog2(TABLE_SLOTS),
  localparam int KEY_W      = 8 * KEY_CHARS
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    opcode,
  input  logic [KEY_W-1:0]   key_chars,
  input  logic [VALUE_W-1:0] new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [IDX_W-1:0]   slot_index,
  output logic               was_defined,
  output logic [VALUE_W-1:0] stored_value
);

  sht_cmd_t cmd;
  sht_sts_t sts;

  sht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sht_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_CHARS   (KEY_CHARS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .key_chars    (key_chars),
    .new_value    (new_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .slot_index   (slot_index),
    .was_defined  (was_defined),
    .stored_value (stored_value)
  );

endmodule

// ===== src/sht_checker.sv =====
// ----------------------------------------------------------------------------
// sht_port_checker
// Port-level checks for the symbol hash table, bound to the top level.
// ----------------------------------------------------------------------------
module sht_port_checker
  import sht_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  localparam int IDX_W      = $clog2(TABLE_SLOTS)
)(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STAT_W-1:0]  status,
  input logic [IDX_W-1:0]   slot_index,
  input logic               was_defined,
  input logic [VALUE_W-1:0] stored_value
);

  // clearing pass holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("item intake open right after reset");

  // one item in flight: intake closes after each accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous still in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_FOUND || status == STAT_EMPTY || status == STAT_FULL))
    else $error("unknown status code");

  a_full_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_FULL) |->
      (slot_index == '0 && !was_defined && stored_value == '0))
    else $error("full result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind symbol_hash_table sht_port_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_sht_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .slot_index   (slot_index),
  .was_defined  (was_defined),
  .stored_value (stored_value)
);
